// ===== src/running_mean_stddev_core_macros.svh =====
// Assertion macros shared by the running mean / deviation core.
`ifndef RUNNING_MEAN_STDDEV_CORE_MACROS_SVH
`define RUNNING_MEAN_STDDEV_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RMSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmsd assertion failed");

// Next-cycle implication, disabled during reset.
`define RMSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmsd assertion failed");

`endif

// ===== src/rmsd_pkg.sv =====
// Package: widths, request codes, controller states and command/status structs.
`default_nettype none

package rmsd_pkg;

    localparam int COUNT_BITS     = 32;
    localparam int OUT_COUNT_BITS = 32;
    localparam int SAMPLE_BITS    = 16;
    localparam int SUM_BITS       = 48;
    localparam int SQ_BITS        = 64;
    localparam int AQ_LIMIT_BITS  = 32;
    localparam int DEV_BITS       = 23;
    localparam int VAR_FRAC       = 16;
    localparam int VAR_LIMIT_BITS = 30;
    localparam int RAD_BITS       = VAR_LIMIT_BITS + VAR_FRAC;
    localparam int ROOT_BITS      = RAD_BITS / 2;
    localparam int SQ_REM_BITS    = ROOT_BITS + 2;
    localparam int DIV_CNT_W      = $clog2(SQ_BITS);
    localparam int SQRT_CNT_W     = $clog2(ROOT_BITS);

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_ADD     = 2'd0;
    localparam t_cmd CMD_REMOVE  = 2'd1;
    localparam t_cmd CMD_REPLACE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REMOVE,
        S_ADD,
        S_CHECK,
        S_DSUM,
        S_MEAN,
        S_DSQ,
        S_MULT,
        S_VAR,
        S_SQRT,
        S_DONE
    } t_state;

    typedef enum logic {
        DIV_SUM,
        DIV_SQ
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     remove;
        logic     add;
        logic     div_start;
        t_div_sel div_sel;
        logic     div_step;
        logic     save_mean;
        logic     mul;
        logic     var_start;
        logic     sqrt_step;
        logic     result_load;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic div_last;
        logic var_skip;
        logic sqrt_last;
        logic out_full;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== src/rmsd_dp.sv =====
// Datapath: store update, shared bit-serial divider, mean square, bit-serial sqrt, result register.
`default_nettype none

module rmsd_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire rmsd_pkg::t_dp_cmd                  i_ctl,
    input  wire rmsd_pkg::t_cmd                     i_cmd,
    input  wire logic signed [rmsd_pkg::SAMPLE_BITS-1:0] i_old_value,
    input  wire logic signed [rmsd_pkg::SAMPLE_BITS-1:0] i_new_value,
    input  wire logic                               i_out_ready,
    output rmsd_pkg::t_dp_sts                       o_sts,
    output logic                                    o_out_valid,
    output logic [rmsd_pkg::OUT_COUNT_BITS-1:0]     o_sample_count,
    output logic signed [rmsd_pkg::SAMPLE_BITS-1:0] o_mean,
    output logic [rmsd_pkg::DEV_BITS-1:0]           o_deviation_q8,
    output logic                                    o_error
);
    import rmsd_pkg::*;

    localparam int SQR_BITS = 2 * SAMPLE_BITS;
    localparam int MEAN_MAX = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int MEAN_MIN_MAG = 2 ** (SAMPLE_BITS - 1);

    // store
    logic [COUNT_BITS-1:0] r_count;
    logic [SUM_BITS-1:0]   r_sum;
    logic [SQ_BITS-1:0]    r_sq;

    // latched request
    t_cmd                  r_op;
    logic [SAMPLE_BITS-1:0] r_old, r_new;
    logic [SQR_BITS-1:0]   r_old_sq, r_new_sq;
    logic                  r_err;
    logic signed [SQR_BITS-1:0] n_old_sq, n_new_sq;

    // divider
    logic [SQ_BITS-1:0]    r_div_num, r_div_quo;
    logic [COUNT_BITS-1:0] r_div_rem;
    logic [DIV_CNT_W-1:0]  r_div_cnt;
    logic [COUNT_BITS:0]   div_sh, div_diff;
    logic                  div_ge;
    logic [SUM_BITS-1:0]   sum_mag;

    // mean / variance
    logic [SUM_BITS-1:0]   r_aq;
    logic                  r_skip;
    logic [SQ_BITS-1:0]    r_mean_sq, mean_sq_c, var_c;
    logic                  var_skip;

    // square root
    logic [RAD_BITS-1:0]    r_rad;
    logic [ROOT_BITS-1:0]   r_root;
    logic [SQ_REM_BITS-1:0] r_sq_rem;
    logic [SQRT_CNT_W-1:0]  r_sqrt_cnt;
    logic                   r_var_big;
    logic [SQ_REM_BITS+1:0] sq_sh, sq_trial, sq_diff;
    logic                   sq_ge;

    // result register
    logic                          r_out_valid;
    logic [OUT_COUNT_BITS-1:0]     r_o_count;
    logic signed [SAMPLE_BITS-1:0] r_o_mean;
    logic [DEV_BITS-1:0]           r_o_dev;
    logic                          r_o_err;
    logic signed [SAMPLE_BITS-1:0] mean_sat;

    logic rem_req, add_req;

    assign rem_req = (r_op == CMD_REMOVE) || (r_op == CMD_REPLACE);
    assign add_req = (r_op == CMD_ADD) || (r_op == CMD_REPLACE);

    assign n_old_sq = i_old_value * i_old_value;
    assign n_new_sq = i_new_value * i_new_value;

    assign sum_mag = r_sum[SUM_BITS-1] ? ((~r_sum) + SUM_BITS'(1)) : r_sum;

    assign div_sh   = {r_div_rem, r_div_num[SQ_BITS-1]};
    assign div_ge   = div_sh >= {1'b0, r_count};
    assign div_diff = div_sh - {1'b0, r_count};

    assign var_skip  = r_sq[SQ_BITS-1] | (|r_div_quo[SUM_BITS-1:AQ_LIMIT_BITS]);
    assign mean_sq_c = r_aq[AQ_LIMIT_BITS-1:0] * r_aq[AQ_LIMIT_BITS-1:0];
    assign var_c     = (!r_skip && (r_div_quo > r_mean_sq)) ? (r_div_quo - r_mean_sq) : '0;

    assign sq_sh    = {r_sq_rem, r_rad[RAD_BITS-1 -: 2]};
    assign sq_trial = (SQ_REM_BITS + 2)'({r_root, 2'b01});
    assign sq_ge    = sq_sh >= sq_trial;
    assign sq_diff  = sq_sh - sq_trial;

    always_comb begin
        if (r_sum[SUM_BITS-1]) begin
            if (r_aq > SUM_BITS'(MEAN_MIN_MAG)) begin
                mean_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            end else begin
                mean_sat = (~r_aq[SAMPLE_BITS-1:0]) + SAMPLE_BITS'(1);
            end
        end else begin
            if (r_aq > SUM_BITS'(MEAN_MAX)) begin
                mean_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            end else begin
                mean_sat = r_aq[SAMPLE_BITS-1:0];
            end
        end
    end

    // control state: store, loop counters, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_div_cnt   <= '0;
            r_sqrt_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.remove && rem_req && (r_count != '0)) begin
                r_count <= r_count - COUNT_BITS'(1);
                r_sum   <= r_sum - {{(SUM_BITS-SAMPLE_BITS){r_old[SAMPLE_BITS-1]}}, r_old};
                r_sq    <= r_sq - {{(SQ_BITS-SQR_BITS){1'b0}}, r_old_sq};
            end else if (i_ctl.add && add_req && (r_count != '1)) begin
                r_count <= r_count + COUNT_BITS'(1);
                r_sum   <= r_sum + {{(SUM_BITS-SAMPLE_BITS){r_new[SAMPLE_BITS-1]}}, r_new};
                r_sq    <= r_sq + {{(SQ_BITS-SQR_BITS){1'b0}}, r_new_sq};
            end
            if (i_ctl.div_start) begin
                r_div_cnt <= (i_ctl.div_sel == DIV_SUM) ? DIV_CNT_W'(SUM_BITS - 1)
                                                        : DIV_CNT_W'(SQ_BITS - 1);
            end else if (i_ctl.div_step) begin
                r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
            end
            if (i_ctl.var_start) begin
                r_sqrt_cnt <= SQRT_CNT_W'(ROOT_BITS - 1);
            end else if (i_ctl.sqrt_step) begin
                r_sqrt_cnt <= r_sqrt_cnt - SQRT_CNT_W'(1);
            end
            if (i_ctl.result_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_op     <= i_cmd;
            r_old    <= i_old_value;
            r_new    <= i_new_value;
            r_old_sq <= n_old_sq;
            r_new_sq <= n_new_sq;
            r_err    <= 1'b0;
        end else if (i_ctl.remove && rem_req && (r_count == '0)) begin
            r_err <= 1'b1;
        end

        if (i_ctl.div_start) begin
            r_div_num <= (i_ctl.div_sel == DIV_SUM) ? {sum_mag, {(SQ_BITS-SUM_BITS){1'b0}}}
                                                    : r_sq;
            r_div_rem <= '0;
            r_div_quo <= '0;
        end else if (i_ctl.div_step) begin
            r_div_num <= {r_div_num[SQ_BITS-2:0], 1'b0};
            r_div_rem <= div_ge ? div_diff[COUNT_BITS-1:0] : div_sh[COUNT_BITS-1:0];
            r_div_quo <= {r_div_quo[SQ_BITS-2:0], div_ge};
        end

        if (i_ctl.save_mean) begin
            r_aq   <= r_div_quo[SUM_BITS-1:0];
            r_skip <= var_skip;
        end
        if (i_ctl.mul) begin
            r_mean_sq <= mean_sq_c;
        end

        if (i_ctl.var_start) begin
            r_rad     <= {var_c[VAR_LIMIT_BITS-1:0], {VAR_FRAC{1'b0}}};
            r_var_big <= |var_c[SQ_BITS-1:VAR_LIMIT_BITS];
            r_root    <= '0;
            r_sq_rem  <= '0;
        end else if (i_ctl.sqrt_step) begin
            r_rad    <= {r_rad[RAD_BITS-3:0], 2'b00};
            r_root   <= {r_root[ROOT_BITS-2:0], sq_ge};
            r_sq_rem <= sq_ge ? sq_diff[SQ_REM_BITS-1:0] : sq_sh[SQ_REM_BITS-1:0];
        end

        if (i_ctl.result_load) begin
            r_o_count <= OUT_COUNT_BITS'(r_count);
            r_o_err   <= r_err;
            if (r_count == '0) begin
                r_o_mean <= '0;
                r_o_dev  <= '0;
            end else begin
                r_o_mean <= mean_sat;
                r_o_dev  <= r_var_big ? '1 : r_root;
            end
        end
    end

    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.div_last   = (r_div_cnt == '0);
    assign o_sts.var_skip   = var_skip;
    assign o_sts.sqrt_last  = (r_sqrt_cnt == '0);
    assign o_sts.out_full   = r_out_valid & ~i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_sample_count = r_o_count;
    assign o_mean         = r_o_mean;
    assign o_deviation_q8 = r_o_dev;
    assign o_error        = r_o_err;

endmodule

`default_nettype wire

// ===== src/rmsd_ctrl.sv =====
// Controller: sequences update, one or two divisions, mean square, square root and result hand-off.
`default_nettype none
`include "running_mean_stddev_core_macros.svh"

module rmsd_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire rmsd_pkg::t_dp_sts i_sts,
    output rmsd_pkg::t_dp_cmd      o_ctl
);
    import rmsd_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_REMOVE;
                end
            end
            S_REMOVE: begin
                o_ctl.remove = 1'b1;
                n_state      = S_ADD;
            end
            S_ADD: begin
                o_ctl.add = 1'b1;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.count_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.div_start = 1'b1;
                    o_ctl.div_sel   = DIV_SUM;
                    n_state         = S_DSUM;
                end
            end
            S_DSUM: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                o_ctl.save_mean = 1'b1;
                if (i_sts.var_skip) begin
                    n_state = S_MULT;
                end else begin
                    o_ctl.div_start = 1'b1;
                    o_ctl.div_sel   = DIV_SQ;
                    n_state         = S_DSQ;
                end
            end
            S_DSQ: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_MULT;
                end
            end
            S_MULT: begin
                o_ctl.mul = 1'b1;
                n_state   = S_VAR;
            end
            S_VAR: begin
                o_ctl.var_start = 1'b1;
                n_state         = S_SQRT;
            end
            S_SQRT: begin
                o_ctl.sqrt_step = 1'b1;
                if (i_sts.sqrt_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_full) begin
                    o_ctl.result_load = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    `RMSD_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, (r_state == S_IDLE) && i_in_valid, r_state == S_REMOVE)
    `RMSD_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, o_ctl.result_load, !i_sts.out_full)
    `RMSD_ASSERT_NXT(a_sum_div_end, i_clk, i_rst_n, (r_state == S_DSUM) && i_sts.div_last, r_state == S_MEAN)
    `RMSD_ASSERT_NXT(a_sqrt_end, i_clk, i_rst_n, (r_state == S_SQRT) && i_sts.sqrt_last, r_state == S_DONE)

endmodule

`default_nettype wire

// ===== src/running_mean_stddev_core.sv =====
// Flow: store update, shared bit-serial divider on the sum (48 steps) then the square sum
// (64 steps; skipped when the mean exceeds 32 bits or the square sum is negative),
// mean square, 23-step bit-serial square root, result load; an empty store goes straight
// to result load, which waits while a result is unaccepted. Requests are taken only in idle.
// Reset: synchronous active low; clears count, sum, square sum, controller and result valid.
`default_nettype none

module running_mean_stddev_core (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_in_valid,
    output logic                                         o_in_ready,
    input  wire rmsd_pkg::t_cmd                          i_cmd,
    input  wire logic signed [rmsd_pkg::SAMPLE_BITS-1:0] i_old_value,
    input  wire logic signed [rmsd_pkg::SAMPLE_BITS-1:0] i_new_value,
    output logic                                         o_out_valid,
    input  wire logic                                    i_out_ready,
    output logic [rmsd_pkg::OUT_COUNT_BITS-1:0]          o_sample_count,
    output logic signed [rmsd_pkg::SAMPLE_BITS-1:0]      o_mean,
    output logic [rmsd_pkg::DEV_BITS-1:0]                o_deviation_q8,
    output logic                                         o_error
);
    import rmsd_pkg::*;

    t_dp_cmd ctl;
    t_dp_sts sts;

    rmsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    rmsd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_cmd          (i_cmd),
        .i_old_value    (i_old_value),
        .i_new_value    (i_new_value),
        .i_out_ready    (i_out_ready),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .o_sample_count (o_sample_count),
        .o_mean         (o_mean),
        .o_deviation_q8 (o_deviation_q8),
        .o_error        (o_error)
    );

endmodule

`default_nettype wire
